// ----- rtl/olrc_pkg.sv -----
// shared constants and types for the oldest-loaded region cache
package olrc_pkg;

    // store geometry
    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 14;
    localparam int STAMP_W     = 32;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W     = KEY_BITS + STAMP_W;

    // capacity register
    localparam int          CAP_W     = 7;
    localparam logic [6:0]  CAP_RESET = 7'd40;
    localparam int          CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // input word kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    // stream word widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // one stored entry as read back during a scan
    typedef struct packed {
        logic                vld;
        logic [SLOT_W-1:0]   slot;
        logic                used;
        logic [KEY_BITS-1:0] key;
        logic [STAMP_W-1:0]  stamp;
    } t_beat;

    // what the scan found over the whole store
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   hit_slot;
        logic                vic_have;
        logic [SLOT_W-1:0]   vic_slot;
        logic [KEY_BITS-1:0] vic_key;
        logic                free_have;
        logic [SLOT_W-1:0]   free_slot;
    } t_scan;

endpackage

// ----- rtl/olrc_scan.sv -----
// scan accumulator: key match, oldest entry and first free slot over one pass
module olrc_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [olrc_pkg::KEY_BITS-1:0] i_req_key,
    input  olrc_pkg::t_beat              i_beat,
    output olrc_pkg::t_scan              o_res
);
    import olrc_pkg::*;

    t_scan              r_res;
    t_scan              n_res;
    logic [STAMP_W-1:0] r_vic_stamp;
    logic [STAMP_W-1:0] n_vic_stamp;
    logic               older;

    // victim order: smaller stamp first, then smaller key
    always_comb begin
        older = !r_res.vic_have
             || (i_beat.stamp < r_vic_stamp)
             || ((i_beat.stamp == r_vic_stamp) && (i_beat.key < r_res.vic_key));
    end

    // fold one entry into the running results
    always_comb begin
        n_res       = r_res;
        n_vic_stamp = r_vic_stamp;
        if (i_start) begin
            n_res = '0;
        end else if (i_beat.vld) begin
            if (i_beat.used) begin
                if (!r_res.hit && (i_beat.key == i_req_key)) begin
                    n_res.hit      = 1'b1;
                    n_res.hit_slot = i_beat.slot;
                end
                if (older) begin
                    n_res.vic_have = 1'b1;
                    n_res.vic_slot = i_beat.slot;
                    n_res.vic_key  = i_beat.key;
                    n_vic_stamp    = i_beat.stamp;
                end
            end else if (!r_res.free_have) begin
                n_res.free_have = 1'b1;
                n_res.free_slot = i_beat.slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
        r_vic_stamp <= n_vic_stamp;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/oldest_loaded_region_cache.sv -----
// top level of the oldest-loaded region cache: control, valid bits and entry memory
//
// Fully associative store of region keys, each stamped with its load time.
// Input channel s_axis: one word per request or clear; tuser selects clear.
// Output channel m_axis: exactly one result word per input word.
// Config channel: i_cfg_valid / o_cfg_ready / i_cfg_data writes the capacity
// register; o_cfg_ready is always high. Writes must go in only between items;
// the block itself does not enforce it. A request reads every slot of the
// entry memory once, one slot per cycle through its single read port, then
// writes back in the write state; its result passes through the last-scan,
// write and done states into the output register, and no new word is taken
// until the block is back in idle. A clear drops all valid bits at once; its
// result goes through the done state into the output register.
// Reset clears the valid bits, the entry count and the output valid flag and
// loads the capacity with 40; no clearing pass is needed, the block takes
// input in the first cycle after reset.
// A finished result waits in the output register while m_axis_tready is
// low; the block accepts the next word meanwhile and holds its own result
// back only until the register is free.
module oldest_loaded_region_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // region_key[13:0], now_seconds[45:14], load_ok[46], zero [47]
    input  logic [olrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // kind[0]
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // hit[0], inserted[1], slot[7:2], evicted[8], evicted_key[22:9], zero [23]
    output logic [olrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [olrc_pkg::CAP_W-1:0]        i_cfg_data
);
    import olrc_pkg::*;

    // controller states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic [CAP_W-1:0]       r_cap;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] n_valid;
    logic [SLOT_W-1:0]      r_idx;
    logic [KEY_BITS-1:0]    r_req_key;
    logic [STAMP_W-1:0]     r_req_now;
    logic                   r_req_ok;
    logic [OUT_DATA_W-1:0]  r_res;
    logic [OUT_DATA_W-1:0]  n_res;
    logic [OUT_DATA_W-1:0]  r_out;
    logic                   r_out_vld;

    // entry memory and its read pipeline
    logic [ENTRY_W-1:0]     mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0]     r_rd_data;
    logic                   r_rd_used;
    logic [SLOT_W-1:0]      r_rd_slot;
    logic                   r_beat_vld;
    logic                   rd_en;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_slot;

    t_beat                  beat;
    t_scan                  scan;
    logic                   in_acc;
    logic                   out_free;
    logic                   scan_start;
    logic [CMP_W-1:0]       cap_eff;
    logic                   full;
    logic                   do_evict;
    logic                   ins_have;
    logic [SLOT_W-1:0]      ins_slot;
    logic                   do_ins;
    logic [SLOT_W-1:0]      res_slot;
    logic [KEY_BITS-1:0]    res_evkey;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = r_out;
    assign m_axis_tvalid = r_out_vld;

    // reads only in the scan state, writes only in the write state
    assign rd_en      = (r_state == S_SCAN);
    assign scan_start = in_acc;

    // entry memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_slot] <= {r_req_key, r_req_now};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx];
        end
        r_rd_used <= r_valid[r_idx];
        r_rd_slot <= r_idx;
    end

    // entry as seen by the scan
    always_comb begin
        beat.vld   = r_beat_vld;
        beat.slot  = r_rd_slot;
        beat.used  = r_rd_used;
        beat.key   = r_rd_data[ENTRY_W-1:STAMP_W];
        beat.stamp = r_rd_data[STAMP_W-1:0];
    end

    olrc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_req_key (r_req_key),
        .i_beat    (beat),
        .o_res     (scan)
    );

    // capacity 0 acts as 1; the count never exceeds the store size
    always_comb begin
        cap_eff = (r_cap == '0) ? CMP_W'(1) : CMP_W'(r_cap);
        full    = (CMP_W'(r_count) >= cap_eff) || (r_count >= CNT_W'(MAX_ENTRIES));
    end

    // miss handling: evict, then place into lowest free slot
    always_comb begin
        do_evict = !scan.hit && full && scan.vic_have;
        if (do_evict && (!scan.free_have || (scan.vic_slot < scan.free_slot))) begin
            ins_slot = scan.vic_slot;
        end else begin
            ins_slot = scan.free_slot;
        end
        ins_have  = scan.free_have || do_evict;
        do_ins    = !scan.hit && r_req_ok && ins_have;
        res_slot  = scan.hit ? scan.hit_slot : (do_ins ? ins_slot : '0);
        res_evkey = do_evict ? scan.vic_key : '0;
    end

    assign wr_en   = (r_state == S_WRITE) && do_ins;
    assign wr_slot = ins_slot;

    // state machine and store update
    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_count = r_count;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser[0] == KIND_CLEAR) begin
                        n_valid = '0;
                        n_count = '0;
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == SLOT_W'(MAX_ENTRIES - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (do_evict) begin
                    n_valid[scan.vic_slot] = 1'b0;
                end
                if (do_ins) begin
                    n_valid[ins_slot] = 1'b1;
                end
                n_count = r_count - CNT_W'(do_evict) + CNT_W'(do_ins);
                n_res   = {1'b0, res_evkey, do_evict, res_slot, do_ins, scan.hit};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_count    <= '0;
            r_cap      <= CAP_RESET;
            r_idx      <= '0;
            r_beat_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_count    <= n_count;
            r_beat_vld <= rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (rd_en) begin
                r_idx <= r_idx + SLOT_W'(1);
            end else begin
                r_idx <= '0;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (in_acc) begin
            r_req_key <= s_axis_tdata[KEY_BITS-1:0];
            r_req_now <= s_axis_tdata[KEY_BITS+STAMP_W-1:KEY_BITS];
            r_req_ok  <= s_axis_tdata[KEY_BITS+STAMP_W];
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    // entry count tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count differs from number of valid entries");

    // memory is never read and written in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("entry memory read and write overlap");

    // a hit neither inserts nor evicts
    a_hit_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out[0] && (r_out[1] || r_out[8])))
        else $error("hit result also reports insert or eviction");

    // a clear empties the store in the next cycle
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (s_axis_tuser[0] == KIND_CLEAR)) |=> (r_valid == '0 && r_count == '0))
        else $error("clear left entries valid");

    // scan results are read only after the last slot is folded in
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ($past(r_state) == S_LAST && !r_beat_vld))
        else $error("write phase entered before scan finished");

endmodule

// ----- test/oldest_loaded_region_cache_tb.sv -----
// testbench for the oldest-loaded region cache: stream driver, lookup predictor and checker
`timescale 1ns / 100ps

module oldest_loaded_region_cache_tb;
    import olrc_pkg::*;

    // one input word as packed on s_axis_tdata
    typedef struct packed {
        logic                pad;
        logic                load_ok;
        logic [STAMP_W-1:0]  now_seconds;
        logic [KEY_BITS-1:0] region_key;
    } t_request_word;

    // one result word as packed on m_axis_tdata
    typedef struct packed {
        logic                pad;
        logic [KEY_BITS-1:0] evicted_key;
        logic                evicted;
        logic [SLOT_W-1:0]   slot;
        logic                inserted;
        logic                hit;
    } t_lookup_result;

    // predicted store contents and the lookups still owed by the block
    class lookup_scoreboard;
        bit                  held       [MAX_ENTRIES];
        bit [KEY_BITS-1:0]   held_key   [MAX_ENTRIES];
        bit [STAMP_W-1:0]    held_stamp [MAX_ENTRIES];
        int unsigned         held_count;
        bit [CAP_W-1:0]      capacity;
        t_lookup_result      expected_lookups[$];
        int unsigned         errors;

        function new();
            int i;
            for (i = 0; i < MAX_ENTRIES; i++) begin
                held[i]       = 1'b0;
                held_key[i]   = '0;
                held_stamp[i] = '0;
            end
            held_count = 0;
            capacity   = CAP_RESET;
            errors     = 0;
        endfunction

        function void set_capacity(input bit [CAP_W-1:0] value);
            capacity = value;
        endfunction

        // zero acts as one, anything past the store size acts as the store size
        function int effective_capacity();
            if (capacity == 0)
                return 1;
            if (capacity > MAX_ENTRIES)
                return MAX_ENTRIES;
            return int'(capacity);
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        // work out the result of one accepted word and update the store
        function void note_word(input logic kind, input logic [KEY_BITS-1:0] key,
                                input logic [STAMP_W-1:0] now, input logic ok);
            t_lookup_result r;
            int i, found, victim, free_slot;
            r = '0;
            if (kind == KIND_CLEAR) begin
                for (i = 0; i < MAX_ENTRIES; i++)
                    held[i] = 1'b0;
                held_count = 0;
            end else begin
                found = -1;
                for (i = 0; i < MAX_ENTRIES; i++)
                    if (found < 0 && held[i] && held_key[i] == key)
                        found = i;
                if (found >= 0) begin
                    // hit leaves the stamp alone
                    r.hit  = 1'b1;
                    r.slot = SLOT_W'(found);
                end else begin
                    // full store: oldest stamp goes, smaller key wins a tie
                    if (held_count >= effective_capacity()) begin
                        victim = -1;
                        for (i = 0; i < MAX_ENTRIES; i++)
                            if (held[i] && (victim < 0 ||
                                    held_stamp[i] < held_stamp[victim] ||
                                    (held_stamp[i] == held_stamp[victim] &&
                                     held_key[i] < held_key[victim])))
                                victim = i;
                        if (victim >= 0) begin
                            held[victim] = 1'b0;
                            if (held_count > 0)
                                held_count--;
                            r.evicted     = 1'b1;
                            r.evicted_key = held_key[victim];
                        end
                    end
                    // successful load goes to the lowest free slot
                    if (ok) begin
                        free_slot = -1;
                        for (i = 0; i < MAX_ENTRIES; i++)
                            if (free_slot < 0 && !held[i])
                                free_slot = i;
                        if (free_slot >= 0) begin
                            held[free_slot]       = 1'b1;
                            held_key[free_slot]   = key;
                            held_stamp[free_slot] = now;
                            held_count++;
                            r.inserted = 1'b1;
                            r.slot     = SLOT_W'(free_slot);
                        end
                    end
                end
            end
            expected_lookups.push_back(r);
        endfunction

        function void compare_field(input string name, input int unsigned exp_val,
                                    input int unsigned act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // compare one accepted result word with the oldest prediction
        function void check_word(input logic [OUT_DATA_W-1:0] data);
            t_lookup_result got, exp_r;
            got = data;
            if (expected_lookups.size() == 0) begin
                $error("result word with no lookup outstanding: %h", data);
                errors++;
                return;
            end
            exp_r = expected_lookups.pop_front();
            compare_field("hit", exp_r.hit, got.hit);
            compare_field("inserted", exp_r.inserted, got.inserted);
            compare_field("slot", exp_r.slot, got.slot);
            compare_field("evicted", exp_r.evicted, got.evicted);
            compare_field("evicted_key", exp_r.evicted_key, got.evicted_key);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CAP_W-1:0]      i_cfg_data = '0;

    lookup_scoreboard      lookups;
    bit                    tx_idle = 1'b1;
    bit                    rx_idle = 1'b1;
    logic [STAMP_W-1:0]    now_clock;

    oldest_loaded_region_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // present one word after a random gap and wait until it is taken
    task automatic send_word(input logic kind, input logic [KEY_BITS-1:0] key,
                             input logic [STAMP_W-1:0] now, input logic ok);
        t_request_word w;
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.pad         = 1'b0;
        w.load_ok     = ok;
        w.now_seconds = now;
        w.region_key  = key;
        s_axis_tdata  <= w;
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        lookups.note_word(kind, key, now, ok);
    endtask

    // stop sending and wait for every outstanding result
    task automatic flush_results();
        s_axis_tvalid <= 1'b0;
        while (lookups.pending() != 0)
            @(posedge i_clk);
    endtask

    // capacity write, only issued while the block is idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        lookups.set_capacity(value);
    endtask

    // random lookups over a key pool a little larger than the capacity
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count);
        logic [KEY_BITS-1:0] pool [$];
        logic [KEY_BITS-1:0] key, last_key;
        logic [STAMP_W-1:0]  stamp;
        logic                kind, ok;
        int                  eff, pick, n;
        flush_results();
        write_capacity(cap);
        eff = lookups.effective_capacity();
        repeat (eff + $urandom_range(1, eff / 4 + 4)) begin
            key = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
            pool.push_back(key);
        end
        last_key = pool[0];
        for (n = 0; n < count; n++) begin
            // stretches with and without gaps on both sides
            if (n % 40 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 149) == 0)
                flush_results();
            pick = $urandom_range(0, 99);
            if (pick < 75)
                key = pool[$urandom_range(0, pool.size() - 1)];
            else if (pick < 90)
                key = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
            else
                key = last_key;
            // mostly advancing time with repeats, some wild stamps
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                stamp = $urandom;
            end else if (pick < 5) begin
                stamp = '1;
            end else if (pick < 6) begin
                stamp = '0;
            end else begin
                now_clock = now_clock + $urandom_range(0, 3);
                stamp     = now_clock;
            end
            ok   = ($urandom_range(0, 99) < 85);
            kind = ($urandom_range(0, 99) == 0) ? KIND_CLEAR : KIND_REQUEST;
            send_word(kind, key, stamp, ok);
            last_key = key;
        end
    endtask

    // result side: random stalls, check every accepted word
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            lookups.check_word(m_axis_tdata);
        end
    end

    // main sequence
    initial begin
        logic [CAP_W-1:0] caps [10];
        int p;
        lookups   = new();
        now_clock = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with a store of two
        write_capacity(7'd2);
        send_word(KIND_CLEAR, 14'd0, 32'd0, 1'b0);           // clear of an empty store
        send_word(KIND_REQUEST, 14'd0, 32'd0, 1'b1);         // lowest key, stamp zero
        send_word(KIND_REQUEST, 14'h3fff, 32'hffff_ffff, 1'b1);
        send_word(KIND_REQUEST, 14'd0, 32'd5, 1'b1);         // hit, stamp kept
        send_word(KIND_REQUEST, 14'd5, 32'd0, 1'b0);         // eviction despite failed load
        send_word(KIND_REQUEST, 14'd7, 32'hffff_ffff, 1'b1);
        send_word(KIND_REQUEST, 14'd9, 32'd100, 1'b1);       // stamp tie, smaller key goes
        send_word(KIND_REQUEST, 14'h3fff, 32'd0, 1'b1);      // hit does not refresh
        send_word(KIND_REQUEST, 14'd11, 32'd200, 1'b1);
        send_word(KIND_REQUEST, 14'd11, 32'd300, 1'b0);      // hit ignores load_ok
        send_word(KIND_CLEAR, 14'h3fff, 32'hffff_ffff, 1'b1);
        send_word(KIND_REQUEST, 14'h3fff, 32'd1, 1'b0);      // failed load, nothing to evict
        send_word(KIND_REQUEST, 14'h2aaa, 32'h5555_5555, 1'b1);
        send_word(KIND_REQUEST, 14'h1555, 32'haaaa_aaaa, 1'b1);

        // capacity zero acts as one, store now holds more than that
        flush_results();
        write_capacity(7'd0);
        send_word(KIND_REQUEST, 14'h1555, 32'd2, 1'b1);
        send_word(KIND_REQUEST, 14'd3, 32'd7, 1'b1);
        send_word(KIND_REQUEST, 14'd4, 32'd8, 1'b0);         // failed load shrinks the count
        send_word(KIND_REQUEST, 14'd6, 32'd9, 1'b1);

        // capacity above the store size acts as the store size
        flush_results();
        write_capacity(7'd127);
        send_word(KIND_REQUEST, 14'd8, 32'd10, 1'b1);
        send_word(KIND_REQUEST, 14'd6, 32'd11, 1'b1);

        // random phases; the drop from 64 to 5 leaves the count above capacity
        caps[0] = 7'd64;
        caps[1] = 7'd5;
        caps[2] = 7'd127;
        caps[3] = 7'd0;
        caps[4] = 7'd1;
        caps[5] = 7'd2;
        caps[6] = CAP_RESET;
        caps[7] = CAP_W'($urandom_range(3, 63));
        caps[8] = CAP_W'($urandom_range(0, 127));
        caps[9] = 7'd17;
        for (p = 0; p < 10; p++)
            run_phase(caps[p], 193);

        flush_results();
        repeat (100) @(posedge i_clk);
        if (lookups.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/olrc_pkg.sv
rtl/olrc_scan.sv
rtl/oldest_loaded_region_cache.sv
test/oldest_loaded_region_cache_tb.sv
